/* src/rchit_pkg.sv */
// Shared types and constants for the ray versus circle hit-time block.
`timescale 1ns / 1ps
package rchit_pkg;

  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [CfgIdxWidth-1:0] CFG_CENTER_X        = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_CENTER_Y        = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_OBSTACLE_RADIUS = 2'd2;

  localparam int unsigned TimeWidth = 32;

  // Control flags that travel with an item along the cell chains.
  typedef struct packed {
    logic valid;
    logic hit;
    logic overlap;
    logic den_zero;
  } ctl_t;

endpackage

/* src/rchit_mul.sv */
// Two-stage unsigned multiplier built from four registered partial products.
`timescale 1ns / 1ps
module rchit_mul #(
  parameter int unsigned AW = 48,
  parameter int unsigned BW = 48
) (
  input  logic             clk_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);
  import rchit_pkg::*;

  localparam int unsigned AL = AW / 2;
  localparam int unsigned AH = AW - AL;
  localparam int unsigned BL = BW / 2;
  localparam int unsigned BH = BW - BL;
  localparam int unsigned PW = AW + BW;

  logic [AL+BL-1:0] pll_q;
  logic [AL+BH-1:0] plh_q;
  logic [AH+BL-1:0] phl_q;
  logic [AH+BH-1:0] phh_q;

  always_ff @(posedge clk_i) begin
    pll_q <= a_i[AL-1:0] * b_i[BL-1:0];
    plh_q <= a_i[AL-1:0] * b_i[BW-1:BL];
    phl_q <= a_i[AW-1:AL] * b_i[BL-1:0];
    phh_q <= a_i[AW-1:AL] * b_i[BW-1:BL];
  end

  always_ff @(posedge clk_i) begin
    p_o <= PW'(pll_q) + (PW'(plh_q) << BL) + (PW'(phl_q) << AL)
         + (PW'(phh_q) << (AL + BL));
  end

endmodule

/* src/rchit_sqrt_cell.sv */
// One cell of the square-root chain: settles one root bit per item.
`timescale 1ns / 1ps
module rchit_sqrt_cell #(
  parameter int unsigned QW    = 96,
  parameter int unsigned SW    = 48,
  parameter int unsigned SIDEW = 100
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rchit_pkg::ctl_t      ctl_i,
  input  logic [QW-1:0]        n_i,
  input  logic [SW+2:0]        rem_i,
  input  logic [SW-1:0]        root_i,
  input  logic [SIDEW-1:0]     side_i,
  output rchit_pkg::ctl_t      ctl_o,
  output logic [QW-1:0]        n_o,
  output logic [SW+2:0]        rem_o,
  output logic [SW-1:0]        root_o,
  output logic [SIDEW-1:0]     side_o
);
  import rchit_pkg::*;

  localparam int unsigned RW = SW + 3;

  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          ge;

  always_comb begin
    rem_sh = {rem_i[RW-3:0], n_i[QW-1:QW-2]};
    trial  = {1'b0, root_i, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    n_o    <= {n_i[QW-3:0], 2'b00};
    rem_o  <= ge ? rem_sh - trial : rem_sh;
    root_o <= {root_i[SW-2:0], ge};
    side_o <= side_i;
  end

endmodule

/* src/rchit_div_cell.sv */
// One cell of the restoring divider chain: settles one quotient bit per item.
`timescale 1ns / 1ps
module rchit_div_cell #(
  parameter int unsigned NW = 66,
  parameter int unsigned DW = 50
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rchit_pkg::ctl_t                    ctl_i,
  input  logic [NW-1:0]                      num_i,
  input  logic [DW-1:0]                      den_i,
  input  logic [DW-1:0]                      rem_i,
  input  logic [rchit_pkg::TimeWidth-1:0]    quo_i,
  input  logic                               ovf_i,
  output rchit_pkg::ctl_t                    ctl_o,
  output logic [NW-1:0]                      num_o,
  output logic [DW-1:0]                      den_o,
  output logic [DW-1:0]                      rem_o,
  output logic [rchit_pkg::TimeWidth-1:0]    quo_o,
  output logic                               ovf_o
);
  import rchit_pkg::*;

  logic [DW:0] rem_sh;
  logic [DW:0] diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem_i, num_i[NW-1]};
    diff   = rem_sh - {1'b0, den_i};
    ge     = rem_sh >= {1'b0, den_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  // Quotient bits that fall off the top of the 32-bit window mark saturation.
  always_ff @(posedge clk_i) begin
    num_o <= {num_i[NW-2:0], 1'b0};
    den_o <= den_i;
    rem_o <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
    quo_o <= {quo_i[TimeWidth-2:0], ge};
    ovf_o <= ovf_i | quo_i[TimeWidth-1];
  end

endmodule

/* src/ray_circle_hit_time.sv */
// Throughput: one item per cycle; busy stays low and results cannot be stalled.
// The square-root chain has 2*COORD_WIDTH cells and the divider chain one cell
// per numerator bit, 2*COORD_WIDTH + 2 + TIME_FRAC_BITS cells.
// Reset clears the configuration registers and all valid flags; no clearing pass.
`timescale 1ns / 1ps
module ray_circle_hit_time #(
  parameter int unsigned COORD_WIDTH    = 24,
  parameter int unsigned TIME_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cfg_we_i,
  input  logic [rchit_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]              cfg_wdata_i,
  input  logic signed [COORD_WIDTH-1:0]       pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]       pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]       vel_x_i,
  input  logic signed [COORD_WIDTH-1:0]       vel_y_i,
  input  logic [COORD_WIDTH-2:0]              body_radius_i,
  output logic                                done_o,
  output logic                                hit_o,
  output logic [rchit_pkg::TimeWidth-1:0]     hit_time_o,
  output logic                                overlapping_o
);
  import rchit_pkg::*;

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned F     = TIME_FRAC_BITS;
  localparam int unsigned AW    = 2 * W;
  localparam int unsigned DDW   = 2 * W + 2;
  localparam int unsigned VDW   = 2 * W + 1;
  localparam int unsigned CRW   = 2 * W + 1;
  localparam int unsigned QW    = 4 * W;
  localparam int unsigned SW    = 2 * W;
  localparam int unsigned DENW  = 2 * W + 2;
  localparam int unsigned NUMW  = DDW + F;
  localparam int unsigned SIDEW = VDW + DDW;

  // Configuration registers.
  logic signed [W-1:0] cx_q, cy_q;
  logic [W-2:0]        rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      rad_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_X:        cx_q  <= cfg_wdata_i;
        CFG_CENTER_Y:        cy_q  <= cfg_wdata_i;
        CFG_OBSTACLE_RADIUS: rad_q <= cfg_wdata_i[W-2:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: offsets and magnitudes.
  logic               v1_q;
  logic signed [W:0]  dx_q, dy_q;
  logic signed [W-1:0] vx_q, vy_q;
  logic [W:0]         adx_q, ady_q;
  logic [W-1:0]       avx_q, avy_q, rsum_q;
  logic signed [W:0]  dx_d, dy_d;

  always_comb begin
    dx_d = $signed({pos_x_i[W-1], pos_x_i}) - $signed({cx_q[W-1], cx_q});
    dy_d = $signed({pos_y_i[W-1], pos_y_i}) - $signed({cy_q[W-1], cy_q});
  end

  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    vx_q   <= vel_x_i;
    vy_q   <= vel_y_i;
    adx_q  <= dx_d[W] ? (W+1)'(0) - dx_d : dx_d;
    ady_q  <= dy_d[W] ? (W+1)'(0) - dy_d : dy_d;
    avx_q  <= vel_x_i[W-1] ? W'(0) - vel_x_i : vel_x_i;
    avy_q  <= vel_y_i[W-1] ? W'(0) - vel_y_i : vel_y_i;
    rsum_q <= {1'b0, rad_q} + {1'b0, body_radius_i};
  end

  // Stage 2: products.
  logic                v2_q;
  logic [2*W-1:0]      vxx_q, vyy_q, rr2_q;
  logic [2*W+1:0]      dxx_q, dyy_q;
  logic signed [2*W:0] vxdx_q, vydy_q, vxdy_q, vydx_q;

  always_ff @(posedge clk_i) begin
    vxx_q  <= avx_q * avx_q;
    vyy_q  <= avy_q * avy_q;
    rr2_q  <= rsum_q * rsum_q;
    dxx_q  <= adx_q * adx_q;
    dyy_q  <= ady_q * ady_q;
    vxdx_q <= vx_q * dx_q;
    vydy_q <= vy_q * dy_q;
    vxdy_q <= vx_q * dy_q;
    vydx_q <= vy_q * dx_q;
  end

  // Stage 3: sums and the early flags.
  logic                v3_q, go3_q, ov3_q;
  logic [AW-1:0]       a_q, rr_q;
  logic [VDW-1:0]      vdm3_q;
  logic [CRW-1:0]      crm_q;
  logic [DDW-1:0]      cabs3_q;
  logic signed [2*W+1:0] vd_d, cr_d;
  logic [DDW-1:0]      dd_d;
  logic [AW:0]         a_d;

  always_comb begin
    vd_d = $signed({vxdx_q[2*W], vxdx_q}) + $signed({vydy_q[2*W], vydy_q});
    cr_d = $signed({vxdy_q[2*W], vxdy_q}) - $signed({vydx_q[2*W], vydx_q});
    dd_d = dxx_q + dyy_q;
    a_d  = {1'b0, vxx_q} + {1'b0, vyy_q};
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d[AW-1:0];
    rr_q    <= rr2_q;
    vdm3_q  <= VDW'((2*W+2)'(0) - vd_d);
    crm_q   <= cr_d[2*W+1] ? CRW'((2*W+2)'(0) - cr_d) : CRW'(cr_d);
    go3_q   <= (a_d != '0) && (vd_d[2*W+1] || (vd_d == '0));
    ov3_q   <= dd_d <= DDW'(rr2_q);
    cabs3_q <= (dd_d >= DDW'(rr2_q)) ? dd_d - DDW'(rr2_q) : DDW'(rr2_q) - dd_d;
  end

  // Stages 4 and 5: wide products a*R*R and cross squared.
  logic [2*AW-1:0]    ar;
  logic [2*CRW-1:0]   cc;

  rchit_mul #(.AW(AW), .BW(AW)) u_mul_ar (
    .clk_i (clk_i),
    .a_i   (a_q),
    .b_i   (rr_q),
    .p_o   (ar)
  );

  rchit_mul #(.AW(CRW), .BW(CRW)) u_mul_cc (
    .clk_i (clk_i),
    .a_i   (crm_q),
    .b_i   (crm_q),
    .p_o   (cc)
  );

  logic                v4_q, v5_q, go4_q, go5_q, ov4_q, ov5_q;
  logic [VDW-1:0]      vdm4_q, vdm5_q;
  logic [DDW-1:0]      cabs4_q, cabs5_q;

  always_ff @(posedge clk_i) begin
    go4_q   <= go3_q;
    go5_q   <= go4_q;
    ov4_q   <= ov3_q;
    ov5_q   <= ov4_q;
    vdm4_q  <= vdm3_q;
    vdm5_q  <= vdm4_q;
    cabs4_q <= cabs3_q;
    cabs5_q <= cabs4_q;
  end

  // Stage 6: discriminant.
  ctl_t            ctl6_q;
  logic [QW-1:0]   q6_q;
  logic [SIDEW-1:0] side6_q;
  logic [2*CRW-1:0] ar_ext;

  assign ar_ext = (2*CRW)'(ar);

  always_ff @(posedge clk_i) begin
    q6_q    <= QW'(ar_ext - cc);
    side6_q <= {vdm5_q, cabs5_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      ctl6_q <= '0;
    end else begin
      v1_q   <= start && !busy;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      ctl6_q <= '{valid: v5_q, hit: go5_q && (ar_ext >= cc), overlap: ov5_q,
                  den_zero: 1'b0};
    end
  end

  // Square-root chain.
  ctl_t             sq_ctl  [0:SW];
  logic [QW-1:0]    sq_n    [0:SW];
  logic [SW+2:0]    sq_rem  [0:SW];
  logic [SW-1:0]    sq_root [0:SW];
  logic [SIDEW-1:0] sq_side [0:SW];

  assign sq_ctl[0]  = ctl6_q;
  assign sq_n[0]    = q6_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = side6_q;

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    rchit_sqrt_cell #(.QW(QW), .SW(SW), .SIDEW(SIDEW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (sq_ctl[i]),
      .n_i    (sq_n[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .side_i (sq_side[i]),
      .ctl_o  (sq_ctl[i+1]),
      .n_o    (sq_n[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // Denominator stage.
  ctl_t            ctl7_q;
  logic [DENW-1:0] den7_q;
  logic [NUMW-1:0] num7_q;
  logic [DENW-1:0] den_d;

  assign den_d = DENW'(sq_side[SW][SIDEW-1:DDW]) + DENW'(sq_root[SW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl7_q <= '0;
    end else begin
      ctl7_q <= '{valid: sq_ctl[SW].valid, hit: sq_ctl[SW].hit,
                  overlap: sq_ctl[SW].overlap, den_zero: den_d == '0};
    end
  end

  always_ff @(posedge clk_i) begin
    den7_q <= den_d;
    num7_q <= {sq_side[SW][DDW-1:0], F'(0)};
  end

  // Divider chain.
  ctl_t                 dv_ctl [0:NUMW];
  logic [NUMW-1:0]      dv_num [0:NUMW];
  logic [DENW-1:0]      dv_den [0:NUMW];
  logic [DENW-1:0]      dv_rem [0:NUMW];
  logic [TimeWidth-1:0] dv_quo [0:NUMW];
  logic                 dv_ovf [0:NUMW];

  assign dv_ctl[0] = ctl7_q;
  assign dv_num[0] = num7_q;
  assign dv_den[0] = den7_q;
  assign dv_rem[0] = '0;
  assign dv_quo[0] = '0;
  assign dv_ovf[0] = 1'b0;

  for (genvar j = 0; j < NUMW; j++) begin : g_div
    rchit_div_cell #(.NW(NUMW), .DW(DENW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (dv_ctl[j]),
      .num_i  (dv_num[j]),
      .den_i  (dv_den[j]),
      .rem_i  (dv_rem[j]),
      .quo_i  (dv_quo[j]),
      .ovf_i  (dv_ovf[j]),
      .ctl_o  (dv_ctl[j+1]),
      .num_o  (dv_num[j+1]),
      .den_o  (dv_den[j+1]),
      .rem_o  (dv_rem[j+1]),
      .quo_o  (dv_quo[j+1]),
      .ovf_o  (dv_ovf[j+1])
    );
  end

  // Output register.
  ctl_t end_ctl;
  assign end_ctl = dv_ctl[NUMW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= end_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_o         <= end_ctl.valid && end_ctl.hit;
    overlapping_o <= end_ctl.valid && end_ctl.overlap;
    if (!end_ctl.hit || end_ctl.den_zero) begin
      hit_time_o <= '0;
    end else if (dv_ovf[NUMW]) begin
      hit_time_o <= '1;
    end else begin
      hit_time_o <= dv_quo[NUMW];
    end
  end

  a_miss_zero_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (hit_time_o == '0))
    else $error("miss reported with a nonzero hit time");

  a_hit_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!end_ctl.valid) |-> (!hit_o && !overlapping_o))
    else $error("result flags raised without a transfer");

  a_done_follows_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (end_ctl.valid && !$past(ctl7_q.valid, NUMW)) |-> $past(!rst_ni, NUMW))
    else $error("divider chain produced an item it never received");

endmodule

/* sim/ray_circle_hit_time_test.sv */
// Self-checking testbench for the ray versus circle hit-time block.
`timescale 1ns / 1ps
module ray_circle_hit_time_test;
  import rchit_pkg::*;

  localparam int unsigned CW = 24;
  localparam int unsigned FRAC = 16;
  localparam int unsigned SETTLE_CYCLES = 4 * CW + FRAC + 20;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam logic [CfgIdxWidth-1:0] CFG_UNUSED = 2'd3;
  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [CW-1:0] pos_x;
    logic [CW-1:0] pos_y;
    logic [CW-1:0] vel_x;
    logic [CW-1:0] vel_y;
    logic [CW-2:0] body_radius;
  } query_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] hit_time;
    logic        overlapping;
  } contact_t;

  typedef enum logic [1:0] {OP_QUERY, OP_WRITE, OP_SETTLE} op_kind_e;

  typedef struct packed {
    op_kind_e               kind;
    query_t                 query;
    logic [CfgIdxWidth-1:0] idx;
    logic [CW-1:0]          data;
  } op_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [CW-1:0] cfg_wdata_i = '0;
  logic signed [CW-1:0] pos_x_i = '0;
  logic signed [CW-1:0] pos_y_i = '0;
  logic signed [CW-1:0] vel_x_i = '0;
  logic signed [CW-1:0] vel_y_i = '0;
  logic [CW-2:0] body_radius_i = '0;
  logic done_o;
  logic hit_o;
  logic [TimeWidth-1:0] hit_time_o;
  logic overlapping_o;

  op_t      pending_ops[$];
  contact_t expected_contacts[$];
  query_t   held_query = '0;
  logic [CW-1:0] obst_cx = '0;
  logic [CW-1:0] obst_cy = '0;
  logic [CW-2:0] obst_rad = '0;
  int unsigned gap_left = 0;
  int unsigned settle_count = 0;
  int unsigned query_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned error_count = 0;

  ray_circle_hit_time #(
    .COORD_WIDTH(CW),
    .TIME_FRAC_BITS(FRAC)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pos_x_i(pos_x_i),
    .pos_y_i(pos_y_i),
    .vel_x_i(vel_x_i),
    .vel_y_i(vel_y_i),
    .body_radius_i(body_radius_i),
    .done_o(done_o),
    .hit_o(hit_o),
    .hit_time_o(hit_time_o),
    .overlapping_o(overlapping_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [63:0] isqrt128(logic [127:0] n);
    logic [127:0] root;
    logic [127:0] bitv;
    root = '0;
    bitv = 128'd1 << 126;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[63:0];
  endfunction

  // Exact integer form of the first root of a*t^2 + 2*h*t + c = 0.
  function automatic contact_t predict_contact(query_t qy, logic [CW-1:0] cx,
                                               logic [CW-1:0] cy, logic [CW-2:0] rad);
    longint dx, dy, vx, vy, vd, cr;
    longint unsigned rs, a, rr, dd, crm, s, den, cabs;
    logic [127:0] ar, cc, quo;
    contact_t res;
    vx = longint'($signed(qy.vel_x));
    vy = longint'($signed(qy.vel_y));
    dx = longint'($signed(qy.pos_x)) - longint'($signed(cx));
    dy = longint'($signed(qy.pos_y)) - longint'($signed(cy));
    rs = longint'(rad) + longint'(qy.body_radius);
    rr = rs * rs;
    a = vx * vx + vy * vy;
    dd = dx * dx + dy * dy;
    vd = vx * dx + vy * dy;
    cr = vx * dy - vy * dx;
    crm = (cr < 0) ? -cr : cr;
    res = '0;
    res.overlapping = (dd <= rr);
    if (a != 0 && vd <= 0) begin
      ar = 128'(a) * 128'(rr);
      cc = 128'(crm) * 128'(crm);
      if (ar >= cc) begin
        s = isqrt128(ar - cc);
        den = longint'(-vd) + s;
        cabs = (dd >= rr) ? dd - rr : rr - dd;
        res.hit = 1'b1;
        if (den != 0) begin
          quo = (128'(cabs) << FRAC) / 128'(den);
          res.hit_time = (quo > 128'(TIME_MAX)) ? TIME_MAX : quo[31:0];
        end
      end
    end
    return res;
  endfunction

  // Driver: one pending operation is issued per free cycle.
  always @(posedge clk_i) begin
    op_t op;
    logic nxt_start;
    logic nxt_we;
    if (rst_ni) begin
      nxt_start = 1'b0;
      nxt_we = 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CENTER_X: obst_cx <= cfg_wdata_i;
          CFG_CENTER_Y: obst_cy <= cfg_wdata_i;
          CFG_OBSTACLE_RADIUS: obst_rad <= cfg_wdata_i[CW-2:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_contacts.push_back(predict_contact(held_query, obst_cx, obst_cy, obst_rad));
      end
      if (start && busy) begin
        nxt_start = 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_ops.size() > 0) begin
        op = pending_ops[0];
        case (op.kind)
          OP_QUERY: begin
            void'(pending_ops.pop_front());
            held_query <= op.query;
            pos_x_i <= op.query.pos_x;
            pos_y_i <= op.query.pos_y;
            vel_x_i <= op.query.vel_x;
            vel_y_i <= op.query.vel_y;
            body_radius_i <= op.query.body_radius;
            nxt_start = 1'b1;
            query_count <= query_count + 1;
            // Alternate stretches of back-to-back transfers with gapped ones.
            gap_left <= ((query_count / 50) % 3 == 0) ? 0 : $urandom_range(0, 7);
          end
          OP_WRITE: begin
            void'(pending_ops.pop_front());
            cfg_idx_i <= op.idx;
            cfg_wdata_i <= op.data;
            nxt_we = 1'b1;
          end
          default: begin
            if (expected_contacts.size() == 0 && !start) begin
              if (settle_count >= SETTLE_CYCLES) begin
                void'(pending_ops.pop_front());
                settle_count <= 0;
              end else begin
                settle_count <= settle_count + 1;
              end
            end
          end
        endcase
      end
      cfg_we_i <= nxt_we;
      start <= nxt_start;
    end
  end

  // Monitor: every result strobe is matched against the oldest prediction.
  always @(posedge clk_i) begin
    contact_t want;
    if (rst_ni && done_o) begin
      if (expected_contacts.size() == 0) begin
        $display("%0t: unexpected result hit=%0b time=%0d overlap=%0b",
                 $time, hit_o, hit_time_o, overlapping_o);
        error_count <= error_count + 1;
      end else begin
        want = expected_contacts.pop_front();
        if (hit_o !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit_o);
          error_count <= error_count + 1;
        end
        if (hit_time_o !== want.hit_time) begin
          $display("%0t: hit_time expected %0d actual %0d", $time, want.hit_time, hit_time_o);
          error_count <= error_count + 1;
        end
        if (overlapping_o !== want.overlapping) begin
          $display("%0t: overlapping expected %0b actual %0b",
                   $time, want.overlapping, overlapping_o);
          error_count <= error_count + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic add_query(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] vx,
                           logic [CW-1:0] vy, logic [CW-2:0] br);
    op_t op;
    op = '0;
    op.kind = OP_QUERY;
    op.query = '{pos_x: px, pos_y: py, vel_x: vx, vel_y: vy, body_radius: br};
    pending_ops.push_back(op);
  endtask

  task automatic add_write(logic [CfgIdxWidth-1:0] idx, logic [CW-1:0] data);
    op_t op;
    op = '0;
    op.kind = OP_WRITE;
    op.idx = idx;
    op.data = data;
    pending_ops.push_back(op);
  endtask

  task automatic add_settle();
    op_t op;
    op = '0;
    op.kind = OP_SETTLE;
    pending_ops.push_back(op);
  endtask

  task automatic add_obstacle(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] rad);
    add_settle();
    add_write(CFG_CENTER_X, cx);
    add_write(CFG_CENTER_Y, cy);
    add_write(CFG_OBSTACLE_RADIUS, rad);
  endtask

  initial begin
    logic [CW-1:0] set_cx[8];
    logic [CW-1:0] set_cy[8];
    logic [CW-1:0] set_rad[8];
    int signed ox, oy, sh;
    logic [CW-1:0] vx, vy;
    set_cx = '{24'd0, 24'h7FFFFF, 24'h800000, 24'd0, 24'h7FFFFF, 24'd0, 24'd0, 24'd0};
    set_cy = '{24'd0, 24'h800000, 24'h7FFFFF, 24'd0, 24'h7FFFFF, 24'd0, 24'd0, 24'd0};
    set_rad = '{24'd2560, 24'h7FFFFF, 24'd0, 24'd0, 24'hFFFFFF, 24'd0, 24'd0, 24'd0};
    for (int k = 5; k < 8; k++) begin
      set_cx[k] = CW'($urandom_range(0, 24'hFFFFFF));
      set_cy[k] = CW'($urandom_range(0, 24'hFFFFFF));
      set_rad[k] = CW'($urandom_range(0, 24'hFFFFFF));
    end

    // Directed items against a centered obstacle of radius 10.
    add_obstacle(24'd0, 24'd0, 24'd2560);
    add_write(CFG_UNUSED, 24'h123456);
    add_query(24'd5000, 24'd0, 24'd0, 24'd0, 23'd0);
    add_query(24'd5000, 24'd0, 24'd256, 24'd0, 23'd0);
    add_query(-24'sd100000, 24'd50000, 24'd256, 24'd0, 23'd0);
    add_query(-24'sd100000, 24'd0, 24'd256, 24'd0, 23'd0);
    add_query(-24'sd100000, 24'd2560, 24'd256, 24'd0, 23'd0);
    add_query(-24'sd100000, 24'd2000, 24'd256, 24'd0, 23'd512);
    add_query(24'd0, 24'd0, 24'd256, 24'd0, 23'd0);
    add_query(24'd100, -24'sd50, -24'sd7, 24'd3, 23'd40);
    add_query(24'h800000, 24'd0, 24'd1, 24'd0, 23'd0);
    add_query(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF);
    add_query(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 23'h7FFFFF);
    add_query(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 23'd0);
    add_query(24'hFFFFFF, 24'd1, 24'd1, 24'hFFFFFF, 23'd1);
    add_query(24'd0, 24'd3000, 24'd0, -24'sd1, 23'd0);

    // A point obstacle: a ray starting at its center grazes with zero time.
    add_obstacle(24'd1234, -24'sd777, 24'd0);
    add_query(24'd1234, -24'sd777, 24'd5, 24'd3, 23'd0);
    add_query(24'd1234, -24'sd777, 24'd5, 24'd3, 23'd1);
    add_query(24'd1000, -24'sd777, 24'd1, 24'd0, 23'd0);

    for (int ph = 0; ph < 8; ph++) begin
      add_obstacle(set_cx[ph], set_cy[ph], set_rad[ph]);
      for (int n = 0; n < 75; n++) begin
        if (n == 40) add_settle();
        if ($urandom_range(0, 9) < 3) begin
          add_query(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                    (CW-1)'($urandom));
        end else begin
          // Mostly rays aimed near the obstacle center with random error.
          sh = $urandom_range(4, 20);
          ox = $signed($urandom_range(0, (1 << (sh + 1)) - 1)) - (1 << sh);
          oy = $signed($urandom_range(0, (1 << (sh + 1)) - 1)) - (1 << sh);
          vx = CW'(-(ox >>> $urandom_range(0, 8)) + $signed($urandom_range(0, 64)) - 32);
          vy = CW'(-(oy >>> $urandom_range(0, 8)) + $signed($urandom_range(0, 64)) - 32);
          add_query(set_cx[ph] + CW'(ox), set_cy[ph] + CW'(oy), vx, vy,
                    (CW-1)'($urandom_range(0, 1 << $urandom_range(0, 22))));
        end
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_ops.size() > 0 || start || expected_contacts.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_contacts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
